/* rtl/mcod_pkg.sv */
// shared types and constants for the matrix chain order block
`default_nettype none

package mcod_pkg;

  localparam int MAX_MATRICES_DEF = 16;
  localparam int DIM_BITS_DEF     = 12;

  localparam int COST_W   = 48;
  localparam int SPLIT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int OUT_TD_W = 56;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOMANY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

  typedef enum logic [1:0] {
    RES_SOLVED  = 2'd0,
    RES_SINGLE  = 2'd1,
    RES_SHORT   = 2'd2,
    RES_TOOMANY = 2'd3
  } res_kind_t;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_CELL0 = 8'b0000_0010,
    S_CELL1 = 8'b0000_0100,
    S_CELL2 = 8'b0000_1000,
    S_STEP  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } ctl_state_t;

  typedef struct packed {
    logic      dim_we;
    logic      cap_pa;
    logic      cap_pb;
    logic      step_vld;
    logic      step_first;
    logic      zero_lo;
    logic      zero_hi;
    logic      cost_we;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic res_ready;
    logic pipe_idle;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/mcod_datapath.sv */
// datapath: dimension and cost memories, split-cost pipeline, result register
`default_nettype none

module mcod_datapath #(
  parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
  parameter int DIM_BITS     = mcod_pkg::DIM_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [DIM_BITS-1:0]                   dim_in,
  input  mcod_pkg::dp_cmd_t                     cmd,
  output mcod_pkg::dp_sts_t                     sts,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]     dim_addr,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]     cost_ra0,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]     cost_ra1,
  input  logic [2*$clog2(MAX_MATRICES)-1:0]     cost_wa,
  input  logic [$clog2(MAX_MATRICES+1)-1:0]     step_idx,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // min_cost [47:0], best_split [51:48], status [53:52], zero pad [55:54]
  output logic [mcod_pkg::OUT_TD_W-1:0]         out_tdata
);
  import mcod_pkg::*;

  localparam int DIDX_W = $clog2(MAX_MATRICES + 1);
  localparam int CA_W   = 2 * $clog2(MAX_MATRICES);
  localparam int CDEPTH = 2 ** CA_W;
  localparam int DW     = DIM_BITS;

  logic [DW-1:0]     dim_mem [0:MAX_MATRICES];
  logic [COST_W-1:0] cost_mem [0:CDEPTH-1];

  logic [DW-1:0]     dim_rd_r;
  logic [COST_W-1:0] c0_rd_r, c1_rd_r;
  logic [DW-1:0]     pa_r, pb_r;

  // stage 1 lines up with the registered memory data
  logic              v1_r, first1_r, zlo1_r, zhi1_r;
  logic [DIDX_W-1:0] idx1_r;
  logic              v2_r, first2_r;
  logic [DIDX_W-1:0] idx2_r;
  logic [2*DW-1:0]   m1_r;
  logic [COST_W:0]   sum2_r;
  logic              v3_r, first3_r;
  logic [DIDX_W-1:0] idx3_r;
  logic [3*DW-1:0]   prod3_r;
  logic [COST_W:0]   sum3_r;

  logic [COST_W-1:0] best_r;
  logic [DIDX_W-1:0] where_r;

  logic                out_valid_r;
  logic [COST_W-1:0]   res_cost_r;
  logic [SPLIT_W-1:0]  res_split_r;
  logic [STATUS_W-1:0] res_status_r;

  logic [2*DW-1:0]   m1_nxt;
  logic [COST_W:0]   sum_nxt;
  logic [3*DW-1:0]   prod_nxt;
  logic [COST_W+1:0] tot;
  logic [COST_W-1:0] q;
  logic              take;

  always_ff @(posedge clk) begin
    if (cmd.dim_we) begin
      dim_mem[dim_addr] <= dim_in;
    end
    dim_rd_r <= dim_mem[dim_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cost_we) begin
      cost_mem[cost_wa] <= best_r;
    end
    c0_rd_r <= cost_mem[cost_ra0];
    c1_rd_r <= cost_mem[cost_ra1];
  end

  // diagonal entries are never stored, they read as zero
  assign m1_nxt  = pa_r * dim_rd_r;
  assign sum_nxt = {1'b0, (zlo1_r ? '0 : c0_rd_r)} + {1'b0, (zhi1_r ? '0 : c1_rd_r)};
  assign prod_nxt = m1_r * pb_r;
  assign tot  = {1'b0, sum3_r} + (COST_W+2)'(prod3_r);
  assign q    = (tot > (COST_W+2)'(COST_MAX)) ? COST_MAX : tot[COST_W-1:0];
  assign take = v3_r && (first3_r || (q < best_r));

  always_ff @(posedge clk) begin
    if (cmd.cap_pa) begin
      pa_r <= dim_rd_r;
    end
    if (cmd.cap_pb) begin
      pb_r <= dim_rd_r;
    end
    first1_r <= cmd.step_first;
    zlo1_r   <= cmd.zero_lo;
    zhi1_r   <= cmd.zero_hi;
    idx1_r   <= step_idx;
    first2_r <= first1_r;
    idx2_r   <= idx1_r;
    m1_r     <= m1_nxt;
    sum2_r   <= sum_nxt;
    first3_r <= first2_r;
    idx3_r   <= idx2_r;
    prod3_r  <= prod_nxt;
    sum3_r   <= sum2_r;
    if (take) begin
      best_r  <= q;
      where_r <= idx3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.step_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sts.res_ready = !out_valid_r || out_tready;
  assign sts.pipe_idle = !v1_r && !v2_r && !v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_SOLVED: begin
          res_cost_r   <= best_r;
          res_split_r  <= SPLIT_W'(where_r);
          res_status_r <= (best_r == COST_MAX) ? ST_SAT : ST_OK;
        end
        RES_SINGLE: begin
          res_cost_r   <= '0;
          res_split_r  <= '0;
          res_status_r <= ST_OK;
        end
        RES_SHORT: begin
          res_cost_r   <= '0;
          res_split_r  <= '0;
          res_status_r <= ST_SHORT;
        end
        default: begin
          res_cost_r   <= '0;
          res_split_r  <= '0;
          res_status_r <= ST_TOOMANY;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_status_r, res_split_r, res_cost_r};

  // a cell result is stored or reported only after its last split has landed
  a_write_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cost_we |-> (!v1_r && !v2_r && !v3_r))
    else $error("cost write while split pipeline busy");

  a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && cmd.res_kind == RES_SOLVED) |-> (!v1_r && !v2_r && !v3_r))
    else $error("result taken while split pipeline busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.res_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* rtl/mcod_ctrl.sv */
// controller: dimension loading and the length / start / split loop sequencer
`default_nettype none

module mcod_ctrl #(
  parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tlast,
  output logic                              in_tready,
  output mcod_pkg::dp_cmd_t                 cmd,
  input  mcod_pkg::dp_sts_t                 sts,
  output logic [$clog2(MAX_MATRICES+1)-1:0] dim_addr,
  output logic [2*$clog2(MAX_MATRICES)-1:0] cost_ra0,
  output logic [2*$clog2(MAX_MATRICES)-1:0] cost_ra1,
  output logic [2*$clog2(MAX_MATRICES)-1:0] cost_wa,
  output logic [$clog2(MAX_MATRICES+1)-1:0] step_idx
);
  import mcod_pkg::*;

  localparam int IW     = $clog2(MAX_MATRICES);
  localparam int DIDX_W = $clog2(MAX_MATRICES + 1);
  localparam int CNT_W  = $clog2(MAX_MATRICES + 2);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_MATRICES + 1);
  localparam logic [DIDX_W-1:0] D_ONE    = DIDX_W'(1);

  ctl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              many_r, many_nxt;
  logic [DIDX_W-1:0] n_r, n_nxt;
  logic [DIDX_W-1:0] len_r, len_nxt;
  logic [IW-1:0]     a_r, a_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [1:0]        drain_r, drain_nxt;
  res_kind_t         kind_r, kind_nxt;

  logic              accept, full;
  logic [CNT_W-1:0]  cnt_after;
  logic              many_after;
  logic [DIDX_W-1:0] a_ext, k_ext, b_ext, k1_ext, b1_ext;
  logic [IW-1:0]     b_idx, k1_idx;
  logic              cell_last;

  assign in_tready  = (state_r == S_LOAD);
  assign accept     = in_tvalid && in_tready;
  assign full       = (cnt_r == CNT_FULL);
  assign cnt_after  = full ? cnt_r : cnt_r + CNT_W'(1);
  assign many_after = many_r || full;

  assign a_ext     = DIDX_W'(a_r);
  assign k_ext     = DIDX_W'(k_r);
  assign b_ext     = a_ext + len_r - D_ONE;
  assign k1_ext    = k_ext + D_ONE;
  assign b1_ext    = b_ext + D_ONE;
  assign b_idx     = b_ext[IW-1:0];
  assign k1_idx    = k1_ext[IW-1:0];
  assign cell_last = ((a_ext + len_r) == n_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    many_nxt  = many_r;
    n_nxt     = n_r;
    len_nxt   = len_r;
    a_nxt     = a_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.res_kind = kind_r;
    dim_addr  = cnt_r[DIDX_W-1:0];
    cost_ra0  = {a_r, k_r};
    cost_ra1  = {k1_idx, b_idx};
    cost_wa   = {a_r, b_idx};
    step_idx  = k1_ext;

    case (state_r)
      S_LOAD: begin
        cmd.dim_we = accept && !full;
        if (accept) begin
          cnt_nxt  = cnt_after;
          many_nxt = many_after;
          if (in_tlast) begin
            cnt_nxt  = '0;
            many_nxt = 1'b0;
            len_nxt  = DIDX_W'(2);
            a_nxt    = '0;
            n_nxt    = DIDX_W'(cnt_after - CNT_W'(1));
            if (many_after) begin
              kind_nxt  = RES_TOOMANY;
              state_nxt = S_EMIT;
            end else if (cnt_after < CNT_W'(2)) begin
              kind_nxt  = RES_SHORT;
              state_nxt = S_EMIT;
            end else if (cnt_after == CNT_W'(2)) begin
              kind_nxt  = RES_SINGLE;
              state_nxt = S_EMIT;
            end else begin
              kind_nxt  = RES_SOLVED;
              state_nxt = S_CELL0;
            end
          end
        end
      end
      S_CELL0: begin
        dim_addr  = a_ext;
        state_nxt = S_CELL1;
      end
      S_CELL1: begin
        cmd.cap_pa = 1'b1;
        dim_addr   = b1_ext;
        state_nxt  = S_CELL2;
      end
      S_CELL2: begin
        cmd.cap_pb = 1'b1;
        k_nxt      = a_r;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        cmd.step_vld   = 1'b1;
        cmd.step_first = (k_r == a_r);
        cmd.zero_lo    = (k_r == a_r);
        cmd.zero_hi    = (k1_ext == b_ext);
        dim_addr       = k1_ext;
        if (k1_ext == b_ext) begin
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_DRAIN: begin
        // wait here until the last split has reached the running minimum
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.cost_we = 1'b1;
        if (cell_last) begin
          if (len_r == n_r) begin
            state_nxt = S_EMIT;
          end else begin
            len_nxt   = len_r + D_ONE;
            a_nxt     = '0;
            state_nxt = S_CELL0;
          end
        end else begin
          a_nxt     = a_r + IW'(1);
          state_nxt = S_CELL0;
        end
      end
      S_EMIT: begin
        if (sts.res_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      many_r  <= 1'b0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      many_r  <= many_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    len_r  <= len_nxt;
    a_r    <= a_nxt;
    k_r    <= k_nxt;
    kind_r <= kind_nxt;
  end

  a_cell_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL0 || state_r == S_STEP || state_r == S_WRITE)
      |-> ((a_ext + len_r) <= n_r))
    else $error("cell runs past end of chain");

  a_split_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (k_ext >= a_ext && k_ext < b_ext))
    else $error("split point outside cell");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("dimension count overflow");

  a_write_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> $past(state_r == S_DRAIN && drain_r == 2'd2))
    else $error("cell written without full drain");

  a_write_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> sts.pipe_idle)
    else $error("cell written while datapath busy");

endmodule

`default_nettype wire

/* rtl/matrix_chain_order_dp.sv */
// Matrix chain order solver (dynamic programming over a triangular cost table).
// Input stream: one beat per matrix dimension p[0], p[1], ... in chain order,
// in_tdata[DIM_BITS-1:0] = dim, in_tlast marks the final dimension of a chain.
// Output stream: one beat per chain, after its last input beat, carrying the
// minimum multiplication count, the outermost split index and a status code.
// Dimension beats are taken one per cycle while the block is loading; in_tready
// drops from the last beat of a chain until its result is in the output register.
// For n matrices the solve runs over n(n-1)/2 table cells; each cell takes setup,
// pipeline drain and write-back states plus one split step per split point.
// The split loop issues one split per cycle through a read / multiply /
// multiply / add-compare pipeline with two read ports on the cost memory.
// Chains with under two dimensions, or with more than MAX_MATRICES+1, give an
// error status at once. Reset returns the block to loading with an empty chain;
// memory contents are not cleared. A stalled out_tready holds the result beat,
// and the next chain can load while it waits.
`default_nettype none

module matrix_chain_order_dp #(
  parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
  parameter int DIM_BITS     = mcod_pkg::DIM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // dim [DIM_BITS-1:0], zero pad above
  input  logic [((DIM_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // min_cost [47:0], best_split [51:48], status [53:52], zero pad [55:54]
  output logic [mcod_pkg::OUT_TD_W-1:0]    out_tdata
);
  import mcod_pkg::*;

  localparam int DIDX_W = $clog2(MAX_MATRICES + 1);
  localparam int CA_W   = 2 * $clog2(MAX_MATRICES);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [DIDX_W-1:0] dim_addr;
  logic [CA_W-1:0]   cost_ra0, cost_ra1, cost_wa;
  logic [DIDX_W-1:0] step_idx;

  mcod_ctrl #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts),
    .dim_addr  (dim_addr),
    .cost_ra0  (cost_ra0),
    .cost_ra1  (cost_ra1),
    .cost_wa   (cost_wa),
    .step_idx  (step_idx)
  );

  mcod_datapath #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dim_in     (in_tdata[DIM_BITS-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .dim_addr   (dim_addr),
    .cost_ra0   (cost_ra0),
    .cost_ra1   (cost_ra1),
    .cost_wa    (cost_wa),
    .step_idx   (step_idx),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* sim/tb_matrix_chain_order_dp.sv */
// testbench for the matrix chain order solver: directed chains, then random chains
`timescale 1ns / 1ps

module tb_matrix_chain_order_dp;
  import mcod_pkg::*;

  localparam int DIM_W      = 12;
  localparam int IN_TD_W    = ((DIM_W + 7) / 8) * 8;
  localparam int DIM_SLOTS  = 17;
  localparam int RAND_ITEMS = 400;
  localparam int QUIET_AT   = 320;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 100;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SPLIT_W-1:0]  split;
    logic [COST_W-1:0]   cost;
  } chain_res_t;

  typedef struct packed {
    logic [4:0]       rep;
    logic [DIM_W-1:0] dim;
    logic             last;
    logic             typed;
    chain_res_t       res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // dim [11:0], zero pad [15:12]
  logic [IN_TD_W-1:0]  in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  // min_cost [47:0], best_split [51:48], status [53:52], zero pad [55:54]
  logic [OUT_TD_W-1:0] out_tdata;

  // predictor state: dimensions of the chain being collected
  logic [DIM_W-1:0] chain_dims [0:DIM_SLOTS-1];
  int               chain_len;
  bit               chain_overflow;

  chain_res_t chain_results_q [$];
  dir_row_t   dir_rows [$];
  chain_res_t got_res;
  chain_res_t want_res;
  int         err_cnt;
  int         results_seen;
  int         stall_cycles;
  bit         quiet_tail;
  bit         long_hold_done;

  matrix_chain_order_dp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // takes one dimension beat; returns 1 with the chain result when it ends the chain
  function automatic bit absorb_dim(input logic [DIM_W-1:0] d, input logic l,
                                    output chain_res_t res);
    logic [COST_W-1:0]  cst [0:255];
    logic [SPLIT_W-1:0] spl [0:255];
    logic [COST_W+1:0]  prod;
    logic [COST_W+1:0]  sum;
    logic [COST_W-1:0]  q;
    logic [COST_W-1:0]  best;
    int                 where;
    int                 n;
    int                 len;
    int                 a;
    int                 b;
    int                 k;
    res = '0;
    if (chain_len < DIM_SLOTS) begin
      chain_dims[chain_len] = d;
      chain_len++;
    end else begin
      chain_overflow = 1'b1;
    end
    if (!l) return 1'b0;
    if (chain_overflow) begin
      res.status = ST_TOOMANY;
    end else if (chain_len < 2) begin
      res.status = ST_SHORT;
    end else begin
      n = chain_len - 1;
      for (a = 0; a < n; a++) begin
        cst[a*16+a] = '0;
        spl[a*16+a] = '0;
      end
      for (len = 2; len <= n; len++) begin
        for (a = 0; a + len <= n; a++) begin
          b = a + len - 1;
          best = '0;
          where = 0;
          for (k = a; k < b; k++) begin
            prod = chain_dims[a] * chain_dims[k+1] * chain_dims[b+1];
            sum = {2'b00, cst[a*16+k]} + {2'b00, cst[(k+1)*16+b]} + prod;
            q = (sum > {2'b00, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
            // later splits win only on a strictly lower cost
            if (k == a || q < best) begin
              best = q;
              where = k + 1;
            end
          end
          cst[a*16+b] = best;
          spl[a*16+b] = where[SPLIT_W-1:0];
        end
      end
      res.cost = cst[n-1];
      res.split = spl[n-1];
      res.status = (res.cost == COST_MAX) ? ST_SAT : ST_OK;
    end
    chain_len = 0;
    chain_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic dir_row_t row(input int rep, input logic [DIM_W-1:0] d, input logic l,
                                   input logic typed, input chain_res_t res);
    dir_row_t r;
    r.rep = rep[4:0];
    r.dim = d;
    r.last = l;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  task automatic push_dim(input logic [DIM_W-1:0] d, input logic l, input logic typed,
                          input chain_res_t typed_res);
    logic       ok;
    chain_res_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TD_W-DIM_W){1'b0}}, d};
    in_tlast  <= l;
    // ready is read mid-cycle, the beat moves on the following rising edge
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    if (absorb_dim(d, l, pred)) chain_results_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic maybe_idle();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return DIM_W'($urandom_range(0, 4095));
    if (r < 8) return DIM_W'($urandom_range(1, 8));
    if (r == 8) return '0;
    return '1;
  endfunction

  // stimulus
  initial begin : drive_in
    int         items;
    int         chains;
    int         clen;
    int         r;
    int         i;
    chain_res_t none;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    chain_len = 0;
    chain_overflow = 1'b0;
    // short chain, single matrix, largest dimensions, zero dimensions, overflow
    dir_rows.push_back(row(1, 12'h7ff, 1'b1, 1'b1, '{ST_SHORT, 4'd0, 48'd0}));
    dir_rows.push_back(row(1, 12'hfff, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'hfff, 1'b1, 1'b1, '{ST_OK, 4'd0, 48'd0}));
    dir_rows.push_back(row(2, 12'hfff, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'hfff, 1'b1, 1'b1, '{ST_OK, 4'd1, 48'd68669157375}));
    dir_rows.push_back(row(1, 12'h000, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'h005, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'h007, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'h000, 1'b1, 1'b0, none));
    dir_rows.push_back(row(17, 12'h555, 1'b0, 1'b0, none));
    dir_rows.push_back(row(1, 12'haaa, 1'b1, 1'b1, '{ST_TOOMANY, 4'd0, 48'd0}));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[j]) begin
      repeat (dir_rows[j].rep) begin
        push_dim(dir_rows[j].dim, dir_rows[j].last, dir_rows[j].typed, dir_rows[j].res);
        maybe_idle();
      end
    end
    items = 0;
    chains = 0;
    while (items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) clen = 1;
      else if (r < 10) clen = $urandom_range(18, 20);
      else if (r < 18) clen = DIM_SLOTS;
      else clen = $urandom_range(2, 8);
      for (i = 0; i < clen; i++) begin
        push_dim(rand_dim(), i == clen - 1, 1'b0, none);
        items++;
        if (items >= QUIET_AT) quiet_tail = 1'b1;
        maybe_idle();
      end
      chains++;
      // one pause with the block fully drained
      if (chains == 20) begin
        in_tvalid <= 1'b0;
        while (chain_results_q.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (chain_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side back-pressure, with one long hold once a few results are out
  initial begin : drive_out
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 4) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // outputs are stable mid-cycle; a beat seen here is taken on the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = out_tdata[COST_W+SPLIT_W+STATUS_W-1:0];
      if (chain_results_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result beat: expected none, got %h", $time, got_res);
      end else begin
        want_res = chain_results_q.pop_front();
        if (got_res.cost !== want_res.cost) begin
          err_cnt++;
          $display("%0t min_cost: expected %0d, got %0d", $time, want_res.cost, got_res.cost);
        end
        if (got_res.split !== want_res.split) begin
          err_cnt++;
          $display("%0t best_split: expected %0d, got %0d", $time, want_res.split,
                   got_res.split);
        end
        if (got_res.status !== want_res.status) begin
          err_cnt++;
          $display("%0t status: expected %0d, got %0d", $time, want_res.status,
                   got_res.status);
        end
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

endmodule

/* sim.f */
rtl/mcod_pkg.sv
rtl/mcod_datapath.sv
rtl/mcod_ctrl.sv
rtl/matrix_chain_order_dp.sv
sim/tb_matrix_chain_order_dp.sv
